// ===== rtl/aip_pkg.sv =====
// Shared types, character codes and digit decode for the ASCII integer parser.
`default_nettype none

package aip_pkg;

   typedef struct packed {
      logic [7:0] character;
      logic       start_req;
      logic [5:0] radix;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [11:0]        end_offset;
      logic               done_res;
   } rsp_type;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LOW_X = 8'h78;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;

   localparam logic [5:0] BASE_AUTO  = 6'd0;
   localparam logic [5:0] BASE_ONE   = 6'd1;
   localparam logic [5:0] BASE_OCT   = 6'd8;
   localparam logic [5:0] BASE_DEC   = 6'd10;
   localparam logic [5:0] BASE_HEX   = 6'd16;
   localparam logic [5:0] BASE_MAX   = 6'd36;

   localparam logic [7:0] DIGIT_NONE = 8'hFF;

   // Decode 0-9, a-f, A-F; anything else is no digit.
   function automatic logic [7:0] char_value(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end else begin
         v = DIGIT_NONE;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/aip_core.sv =====
// Parser state registers and the per-character next-state and result logic.
`default_nettype none

module aip_core #(
   parameter int unsigned MAX_CHARS = 4095
) (
   input  wire             clock,
   input  wire             reset,
   input  wire             load,
   input  aip_pkg::req_type req,
   output aip_pkg::rsp_type rsp_next
);
   import aip_pkg::*;

   localparam int unsigned PosW = $clog2(MAX_CHARS + 1);

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic            neg_ff, neg_in;
   logic [5:0]      base_ff, base_in;
   logic [31:0]     mag_ff, mag_in;
   logic [PosW-1:0] cons_ff, cons_in;
   logic [PosW-1:0] pos_ff, pos_in;

   phase_type       ph_v;
   phase_type       cur;
   logic [PosW-1:0] pos_v;
   logic [PosW-1:0] pos_adv;
   logic [7:0]      c;
   logic [7:0]      dv;
   logic            taken;
   logic            is_space;

   always_comb begin
      c        = req.character;
      ph_v     = phase_ff;
      neg_in   = neg_ff;
      base_in  = base_ff;
      mag_in   = mag_ff;
      cons_in  = cons_ff;
      pos_v    = pos_ff;
      // restart aborts whatever string is in progress
      if (req.start_req) begin
         ph_v    = PH_SPACE;
         neg_in  = 1'b0;
         base_in = req.radix;
         mag_in  = '0;
         cons_in = '0;
         pos_v   = '0;
         if (req.radix == BASE_ONE || req.radix > BASE_MAX) begin
            ph_v = PH_DONE;
         end
      end
      pos_in   = pos_v;
      pos_adv  = (32'(pos_v) < MAX_CHARS) ? pos_v + PosW'(1) : pos_v;
      is_space = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
      dv       = char_value(c);
      taken    = 1'b0;
      cur      = ph_v;
      phase_in = ph_v;

      if (cur == PH_SPACE) begin
         if (is_space) begin
            pos_in = pos_adv;
            taken  = 1'b1;
         end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            neg_in   = (c == CHAR_MINUS);
            pos_in   = pos_adv;
            phase_in = PH_SIGNED;
            taken    = 1'b1;
         end else begin
            cur = PH_SIGNED;
         end
      end
      if (!taken && cur == PH_SIGNED) begin
         if (c == CHAR_ZERO && (base_in == BASE_AUTO || base_in == BASE_HEX)) begin
            pos_in   = pos_adv;
            cons_in  = pos_adv;
            phase_in = PH_ZERO;
            taken    = 1'b1;
         end else begin
            if (base_in == BASE_AUTO) base_in = BASE_DEC;
            cur = PH_DIGITS;
         end
      end
      if (!taken && cur == PH_ZERO) begin
         if ((c == CHAR_LOW_X || c == CHAR_UP_X) &&
             (base_in == BASE_AUTO || base_in == BASE_HEX)) begin
            pos_in   = pos_adv;
            base_in  = BASE_HEX;
            phase_in = PH_DIGITS;
            taken    = 1'b1;
         end else begin
            if (base_in == BASE_AUTO) base_in = BASE_OCT;
            cur = PH_DIGITS;
         end
      end
      if (!taken && cur == PH_DIGITS) begin
         if (dv < {2'b00, base_in}) begin
            mag_in   = mag_in * 32'(base_in) + 32'(dv);
            pos_in   = pos_adv;
            cons_in  = pos_adv;
            phase_in = PH_DIGITS;
         end else begin
            phase_in = PH_DONE;
         end
      end

      rsp_next.value      = $signed(neg_in ? (32'd0 - mag_in) : mag_in);
      rsp_next.end_offset = 12'(cons_in);
      rsp_next.done_res   = (phase_in == PH_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         neg_ff   <= 1'b0;
         base_ff  <= '0;
         mag_ff   <= '0;
         cons_ff  <= '0;
         pos_ff   <= '0;
      end else if (load) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         base_ff  <= base_in;
         mag_ff   <= mag_in;
         cons_ff  <= cons_in;
         pos_ff   <= pos_in;
      end
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) <= MAX_CHARS)
      else $error("position beyond limit");

   a_cons_le_pos: assert property (@(posedge clock) disable iff (reset)
      cons_ff <= pos_ff)
      else $error("consumed count ahead of position");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE && load && !req.start_req) |=>
         (phase_ff == PH_DONE && $stable(mag_ff) && $stable(cons_ff)))
      else $error("state changed after parse finished");

endmodule

`default_nettype wire

// ===== rtl/aip_out_buf.sv =====
// Two-entry result buffer: output register plus skid entry.
`default_nettype none

module aip_out_buf (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  aip_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output aip_pkg::rsp_type rsp_data
);
   import aip_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    fire;

   always_comb begin
      fire          = out_valid_ff && !rsp_stall;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || fire) begin
         if (skid_valid_ff) begin
            // advance the skid entry; no push can arrive while it is full
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without output entry");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("request pushed into full buffer");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (fire && skid_valid_ff) |=> (out_valid_ff && out_ff == $past(skid_ff)))
      else $error("skid entry lost on drain");

endmodule

`default_nettype wire

// ===== rtl/ascii_integer_parser.sv =====
// Top level of the streaming ASCII-to-integer parser.
// A request's result is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one request per cycle while req_stall is low.
// A two-entry result buffer keeps requests flowing while one result waits.
// Reset (synchronous, active high) empties the buffer and sets the parser as if a
// string had started with automatic base detection.
`default_nettype none

module ascii_integer_parser #(
   parameter int unsigned MAX_CHARS = 4095
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  aip_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output aip_pkg::rsp_type rsp_data
);
   import aip_pkg::*;

   rsp_type step_rsp;
   logic    accept;
   logic    full;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   aip_core #(
      .MAX_CHARS(MAX_CHARS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .req      (req_data),
      .rsp_next (step_rsp)
   );

   aip_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (step_rsp),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
